[rtl/core/vcsd_pkg.sv]
// vcsd_pkg: item types, frame identifiers and fuel constants of the CAN signal decoder
// no dependencies; used by every module under rtl/core
package vcsd_pkg;

  // identifiers of the recognised extended frames
  localparam logic [28:0] ID_IGN_FUEL   = 29'h0621_4000;
  localparam logic [28:0] ID_SPEED      = 29'h0439_4000;
  localparam logic [28:0] ID_PEDAL      = 29'h0439_4100;
  localparam logic [28:0] ID_ENGINE     = 29'h0421_4001;
  localparam logic [28:0] ID_DIST_RANGE = 29'h0C01_4003;
  localparam logic [28:0] ID_BRAKE      = 29'h0302_9000;
  localparam logic [28:0] ID_ESP        = 29'h0631_4000;

  // fuel dose accumulator and nanolitre conversion
  localparam int unsigned DOSE_W     = 17;
  localparam int unsigned MUL_W      = 14;
  localparam int unsigned DOSE_SHIFT = 9;
  localparam int unsigned NL_W       = DOSE_W + MUL_W - DOSE_SHIFT;
  localparam logic [DOSE_W-1:0] DOSE_LIMIT = 17'd32777;
  localparam logic [MUL_W-1:0]  DOSE_MUL   = 14'd15621;

  // all-ones invalid codes
  localparam logic [6:0]  LEVEL_INVALID = 7'h7F;
  localparam logic [7:0]  BYTE_INVALID  = 8'hFF;
  localparam logic [15:0] WORD_INVALID  = 16'hFFFF;
  localparam logic [19:0] DIST_INVALID  = 20'hF_FFFF;
  localparam logic [14:0] RANGE_INVALID = 15'h7FFF;
  localparam logic [11:0] BRAKE_INVALID = 12'hFFF;
  localparam logic [7:0]  OIL_OFFSET    = 8'd40;
  localparam int unsigned IGN_BIT       = 6;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [28:0] frame_id;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic              ignition_on;
    logic [6:0]        tank_level;
    logic [7:0]        speed;
    logic [7:0]        pedal;
    logic [12:0]       rpm;
    logic signed [7:0] oil_degc;
    logic [19:0]       distance;
    logic [14:0]       range_km;
    logic [11:0]       brake;
    logic [1:0]        esp_status;
    logic [47:0]       fuel_total_nl;
    logic [31:0]       timestamp_ms;
  } out_item_t;

  // classified request kinds
  typedef enum logic [3:0] {
    OP_UNKNOWN = 4'd0,
    OP_IGN     = 4'd1,
    OP_SPEED   = 4'd2,
    OP_PEDAL   = 4'd3,
    OP_ENGINE  = 4'd4,
    OP_DIST    = 4'd5,
    OP_BRAKE   = 4'd6,
    OP_ESP     = 4'd7,
    OP_CLEAR   = 4'd8
  } frame_op_e;

  typedef struct packed {
    frame_op_e        op;
    logic [6:0][7:0]  bytes;
    logic [31:0]      now_ms;
  } queue_item_t;

  typedef enum logic [1:0] {
    FUEL_HOLD  = 2'd0,
    FUEL_ADD   = 2'd1,
    FUEL_CLEAR = 2'd2
  } fuel_cmd_e;

  typedef struct packed {
    fuel_cmd_e         cmd;
    logic [DOSE_W-1:0] dose;
  } fuel_req_t;

  // decoded signals, everything but the fuel total
  typedef struct packed {
    logic              ignition_on;
    logic [6:0]        tank_level;
    logic [7:0]        speed;
    logic [7:0]        pedal;
    logic [12:0]       rpm;
    logic signed [7:0] oil_degc;
    logic [19:0]       distance;
    logic [14:0]       range_km;
    logic [11:0]       brake;
    logic [1:0]        esp_status;
    logic [31:0]       timestamp_ms;
  } sig_snap_t;

endpackage

[rtl/core/vcsd_front.sv]
// vcsd_front: accepts input requests and classifies them by frame identifier
// depends on vcsd_pkg
module vcsd_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  vcsd_pkg::in_item_t    in_data_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output vcsd_pkg::queue_item_t q_item_o
);

  vcsd_pkg::frame_op_e op;

  always_comb begin
    if (in_data_i.kind == vcsd_pkg::KIND_CLEAR) begin
      op = vcsd_pkg::OP_CLEAR;
    end else begin
      case (in_data_i.frame_id)
        vcsd_pkg::ID_IGN_FUEL:   op = vcsd_pkg::OP_IGN;
        vcsd_pkg::ID_SPEED:      op = vcsd_pkg::OP_SPEED;
        vcsd_pkg::ID_PEDAL:      op = vcsd_pkg::OP_PEDAL;
        vcsd_pkg::ID_ENGINE:     op = vcsd_pkg::OP_ENGINE;
        vcsd_pkg::ID_DIST_RANGE: op = vcsd_pkg::OP_DIST;
        vcsd_pkg::ID_BRAKE:      op = vcsd_pkg::OP_BRAKE;
        vcsd_pkg::ID_ESP:        op = vcsd_pkg::OP_ESP;
        default:                 op = vcsd_pkg::OP_UNKNOWN;
      endcase
    end
  end

  // byte7 carries nothing for the known frames
  assign q_item_o.op     = op;
  assign q_item_o.bytes  = {in_data_i.byte6, in_data_i.byte5, in_data_i.byte4,
                            in_data_i.byte3, in_data_i.byte2, in_data_i.byte1,
                            in_data_i.byte0};
  assign q_item_o.now_ms = in_data_i.now_ms;

  assign q_valid_o  = in_valid_i;
  assign in_ready_o = q_ready_i;

endmodule

[rtl/core/vcsd_queue.sv]
// vcsd_queue: short fifo of classified requests between front and back ends
// depends on vcsd_pkg
module vcsd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  vcsd_pkg::queue_item_t push_item_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output vcsd_pkg::queue_item_t pop_item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  vcsd_pkg::queue_item_t entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entries_q[rd_ptr_q];

  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/core/vcsd_exec.sv]
// vcsd_exec: applies classified requests to the signal registers and dose accumulator
// depends on vcsd_pkg; feeds the fuel stage with a snapshot and a fuel request
module vcsd_exec (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  vcsd_pkg::queue_item_t q_item_i,
  output logic                  ex_valid_o,
  input  logic                  ex_ready_i,
  output vcsd_pkg::sig_snap_t   ex_snap_o,
  output vcsd_pkg::fuel_req_t   ex_fuel_o
);

  vcsd_pkg::sig_snap_t snap_q, snap_d;
  vcsd_pkg::fuel_req_t fuel_q, fuel_d;
  logic [vcsd_pkg::DOSE_W-1:0] dose_q, dose_d, dose_sum;
  logic [15:0] speed_raw, rpm_raw, dose_raw, range_raw, brake_raw;
  logic [19:0] dist_raw;
  logic [6:0]  level_raw;
  logic        valid_q, take, ign_new;

  assign q_ready_o = !valid_q || ex_ready_i;
  assign take      = q_valid_i && q_ready_o;

  assign level_raw = q_item_i.bytes[5][6:0];
  assign speed_raw = {q_item_i.bytes[0], q_item_i.bytes[1]};
  assign rpm_raw   = {q_item_i.bytes[6], q_item_i.bytes[5]};
  assign dose_raw  = {q_item_i.bytes[4], q_item_i.bytes[5]};
  assign dist_raw  = {q_item_i.bytes[1][3:0], q_item_i.bytes[2], q_item_i.bytes[3]};
  assign range_raw = {q_item_i.bytes[4], q_item_i.bytes[5]};
  assign brake_raw = {q_item_i.bytes[5], q_item_i.bytes[6]};
  assign ign_new   = q_item_i.bytes[2][vcsd_pkg::IGN_BIT];

  // accumulator stays below the limit, so the sum fits its width
  assign dose_sum = dose_q + vcsd_pkg::DOSE_W'(dose_raw);

  always_comb begin
    snap_d      = snap_q;
    dose_d      = dose_q;
    fuel_d.cmd  = vcsd_pkg::FUEL_HOLD;
    fuel_d.dose = '0;
    case (q_item_i.op)
      vcsd_pkg::OP_CLEAR: begin
        dose_d     = '0;
        fuel_d.cmd = vcsd_pkg::FUEL_CLEAR;
      end
      vcsd_pkg::OP_IGN: begin
        if (snap_q.ignition_on && !ign_new && (dose_q != '0)) begin
          fuel_d.cmd  = vcsd_pkg::FUEL_ADD;
          fuel_d.dose = dose_q;
          dose_d      = '0;
        end
        snap_d.ignition_on = ign_new;
        if (level_raw != vcsd_pkg::LEVEL_INVALID) begin
          snap_d.tank_level = level_raw;
        end
      end
      vcsd_pkg::OP_SPEED: begin
        if (!snap_q.ignition_on) begin
          snap_d.speed = '0;
        end else if (speed_raw != vcsd_pkg::WORD_INVALID) begin
          snap_d.speed = speed_raw[11:4];
        end
      end
      vcsd_pkg::OP_PEDAL: begin
        if (q_item_i.bytes[3] != vcsd_pkg::BYTE_INVALID) begin
          snap_d.pedal = q_item_i.bytes[3];
        end
      end
      vcsd_pkg::OP_ENGINE: begin
        if (!snap_q.ignition_on) begin
          snap_d.rpm = '0;
        end else begin
          if (rpm_raw != vcsd_pkg::WORD_INVALID) begin
            snap_d.rpm = rpm_raw[15:3];
          end
          if (dose_raw != vcsd_pkg::WORD_INVALID) begin
            if (dose_sum >= vcsd_pkg::DOSE_LIMIT) begin
              fuel_d.cmd  = vcsd_pkg::FUEL_ADD;
              fuel_d.dose = dose_sum;
              dose_d      = '0;
            end else begin
              dose_d = dose_sum;
            end
          end
        end
        snap_d.oil_degc = q_item_i.bytes[3] - vcsd_pkg::OIL_OFFSET;
      end
      vcsd_pkg::OP_DIST: begin
        if (dist_raw != vcsd_pkg::DIST_INVALID) begin
          snap_d.distance = dist_raw;
        end
        if (range_raw[14:0] != vcsd_pkg::RANGE_INVALID) begin
          snap_d.range_km = range_raw[14:0];
        end
      end
      vcsd_pkg::OP_BRAKE: begin
        if (brake_raw[11:0] != vcsd_pkg::BRAKE_INVALID) begin
          snap_d.brake = brake_raw[11:0];
        end
      end
      vcsd_pkg::OP_ESP: begin
        snap_d.esp_status = (q_item_i.bytes[5] != vcsd_pkg::BYTE_INVALID) ?
                            q_item_i.bytes[5][1:0] : 2'd0;
      end
      default: begin
      end
    endcase
    if ((q_item_i.op != vcsd_pkg::OP_UNKNOWN) && (q_item_i.op != vcsd_pkg::OP_CLEAR)) begin
      snap_d.timestamp_ms = q_item_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      snap_q  <= '0;
      dose_q  <= '0;
      fuel_q  <= '0;
    end else begin
      if (q_ready_o) begin
        valid_q <= q_valid_i;
      end
      if (take) begin
        snap_q <= snap_d;
        dose_q <= dose_d;
        fuel_q <= fuel_d;
      end
    end
  end

  assign ex_valid_o = valid_q;
  assign ex_snap_o  = snap_q;
  assign ex_fuel_o  = fuel_q;

endmodule

[rtl/core/vcsd_fuel.sv]
// vcsd_fuel: dose to nanolitre multiply, saturating fuel total and output register
// depends on vcsd_pkg
module vcsd_fuel #(
  parameter int unsigned FUEL_TOTAL_BITS = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ex_valid_i,
  output logic                ex_ready_o,
  input  vcsd_pkg::sig_snap_t ex_snap_i,
  input  vcsd_pkg::fuel_req_t ex_fuel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vcsd_pkg::out_item_t out_data_o
);

  localparam int unsigned ProdW = vcsd_pkg::DOSE_W + vcsd_pkg::MUL_W;

  // multiply stage
  logic                      mul_valid_q;
  vcsd_pkg::sig_snap_t       mul_snap_q;
  vcsd_pkg::fuel_cmd_e       mul_cmd_q;
  logic [vcsd_pkg::NL_W-1:0] mul_nl_q;
  logic [ProdW-1:0]          product;

  // total stage
  logic                       out_valid_q;
  vcsd_pkg::sig_snap_t        out_snap_q;
  logic [FUEL_TOTAL_BITS-1:0] total_q, total_d;
  logic [FUEL_TOTAL_BITS:0]   total_sum;
  logic                       out_en, mul_en;

  assign out_en     = !out_valid_q || out_ready_i;
  assign mul_en     = !mul_valid_q || out_en;
  assign ex_ready_o = mul_en;

  assign product = ProdW'(ex_fuel_i.dose) * ProdW'(vcsd_pkg::DOSE_MUL);

  assign total_sum = {1'b0, total_q} + (FUEL_TOTAL_BITS + 1)'(mul_nl_q);

  always_comb begin
    case (mul_cmd_q)
      vcsd_pkg::FUEL_CLEAR: total_d = '0;
      vcsd_pkg::FUEL_ADD:   total_d = total_sum[FUEL_TOTAL_BITS] ? '1 :
                                      total_sum[FUEL_TOTAL_BITS-1:0];
      default:              total_d = total_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      mul_cmd_q   <= vcsd_pkg::FUEL_HOLD;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      if (mul_en) begin
        mul_valid_q <= ex_valid_i;
        if (ex_valid_i) begin
          mul_cmd_q <= ex_fuel_i.cmd;
        end
      end
      if (out_en) begin
        out_valid_q <= mul_valid_q;
        if (mul_valid_q) begin
          total_q <= total_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en && ex_valid_i) begin
      mul_snap_q <= ex_snap_i;
      mul_nl_q   <= product[ProdW-1:vcsd_pkg::DOSE_SHIFT];
    end
    if (out_en && mul_valid_q) begin
      out_snap_q <= mul_snap_q;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_data_o.ignition_on   = out_snap_q.ignition_on;
  assign out_data_o.tank_level    = out_snap_q.tank_level;
  assign out_data_o.speed         = out_snap_q.speed;
  assign out_data_o.pedal         = out_snap_q.pedal;
  assign out_data_o.rpm           = out_snap_q.rpm;
  assign out_data_o.oil_degc      = out_snap_q.oil_degc;
  assign out_data_o.distance      = out_snap_q.distance;
  assign out_data_o.range_km      = out_snap_q.range_km;
  assign out_data_o.brake         = out_snap_q.brake;
  assign out_data_o.esp_status    = out_snap_q.esp_status;
  assign out_data_o.fuel_total_nl = 48'(total_q);
  assign out_data_o.timestamp_ms  = out_snap_q.timestamp_ms;

endmodule

[rtl/core/vehicle_can_signal_decoder.sv]
// vehicle_can_signal_decoder: top level of the CAN signal decoder
// depends on vcsd_pkg, vcsd_front, vcsd_queue, vcsd_exec and vcsd_fuel
//
// usage
//   input channel (in_valid_i / in_ready_o / in_data_i) takes one request per
//   cycle while in_ready_o is high: a received frame (kind 0) or a clear of
//   the fuel totals (kind 1)
//   output channel (out_valid_o / out_ready_i / out_data_o) gives exactly one
//   snapshot of all decoded signals per request, in request order
//   path: queue, signal update, dose multiply, fuel total registers, in order
//   throughput: one request per cycle sustained while out_ready_i is high,
//   set by the signal update loop in the exec stage
//   reset clears every signal, the dose accumulator, the fuel total and all
//   valid flags; in_ready_o is already high as reset is released, so the
//   first edge after release can take a request
//   when the receiver stalls, the output and multiply stages hold, the exec
//   stage holds, and the request queue fills; in_ready_o drops only once
//   the queue is full
//
module vehicle_can_signal_decoder #(
  parameter int unsigned FUEL_TOTAL_BITS = 48,
  parameter int unsigned QUEUE_DEPTH     = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vcsd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vcsd_pkg::out_item_t out_data_o
);

  // front to queue
  logic                  fq_valid, fq_ready;
  vcsd_pkg::queue_item_t fq_item;

  // queue to exec
  logic                  qe_valid, qe_ready;
  vcsd_pkg::queue_item_t qe_item;

  // exec to fuel stage
  logic                  ef_valid, ef_ready;
  vcsd_pkg::sig_snap_t   ef_snap;
  vcsd_pkg::fuel_req_t   ef_fuel;

  // classify by identifier
  vcsd_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_item_o   (fq_item)
  );

  // decouples the front from back-end stalls
  vcsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (qe_valid),
    .pop_ready_i  (qe_ready),
    .pop_item_o   (qe_item)
  );

  // signal registers and dose accumulator
  vcsd_exec u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (qe_valid),
    .q_ready_o  (qe_ready),
    .q_item_i   (qe_item),
    .ex_valid_o (ef_valid),
    .ex_ready_i (ef_ready),
    .ex_snap_o  (ef_snap),
    .ex_fuel_o  (ef_fuel)
  );

  // nanolitre conversion, saturating total, output register
  vcsd_fuel #(
    .FUEL_TOTAL_BITS (FUEL_TOTAL_BITS)
  ) u_fuel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ex_valid_i  (ef_valid),
    .ex_ready_o  (ef_ready),
    .ex_snap_i   (ef_snap),
    .ex_fuel_i   (ef_fuel),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/sv/vcsd_tb_pkg.sv]
// vcsd_tb_pkg: snapshot tracker for the CAN signal decoder testbench
// predicts the decoded signal snapshot of every request; depends on vcsd_pkg
package vcsd_tb_pkg;
  import vcsd_pkg::*;

  localparam int unsigned TOTAL_NL_BITS = 48;

  class snapshot_tracker;
    logic              ign;
    logic [6:0]        level;
    logic [7:0]        speed;
    logic [7:0]        pedal;
    logic [12:0]       rpm;
    logic [7:0]        oil;
    logic [19:0]       odo;
    logic [14:0]       range_km;
    logic [11:0]       brake;
    logic [1:0]        esp;
    logic [DOSE_W-1:0] dose_acc;
    logic [63:0]       total_nl;
    logic [31:0]       stamp;
    out_item_t         expected_snaps[$];
    int                errors;

    function new();
      ign      = 1'b0;
      level    = '0;
      speed    = '0;
      pedal    = '0;
      rpm      = '0;
      oil      = '0;
      odo      = '0;
      range_km = '0;
      brake    = '0;
      esp      = '0;
      dose_acc = '0;
      total_nl = '0;
      stamp    = '0;
      errors   = 0;
    endfunction

    // convert the dose to nanolitres and add it, saturating
    function void flush_dose();
      logic [63:0] nl;
      logic [63:0] ceiling;
      logic [63:0] sum;
      nl      = (64'(dose_acc) * 64'(DOSE_MUL)) >> DOSE_SHIFT;
      ceiling = (64'd1 << TOTAL_NL_BITS) - 64'd1;
      sum     = total_nl + nl;
      if (sum < total_nl || sum > ceiling) begin
        sum = ceiling;
      end
      total_nl = sum;
      dose_acc = '0;
    endfunction

    function int pending();
      return expected_snaps.size();
    endfunction

    function void note_request(in_item_t req);
      logic [15:0] word;
      logic        ign_new;
      logic        matched;
      out_item_t   snap;
      if (req.kind == KIND_CLEAR) begin
        total_nl = '0;
        dose_acc = '0;
      end else begin
        matched = 1'b1;
        case (req.frame_id)
          ID_IGN_FUEL: begin
            ign_new = req.byte2[IGN_BIT];
            if (ign && !ign_new && dose_acc != '0) begin
              flush_dose();
            end
            ign = ign_new;
            if (req.byte5[6:0] != LEVEL_INVALID) begin
              level = req.byte5[6:0];
            end
          end
          ID_SPEED: begin
            if (ign) begin
              word = {req.byte0, req.byte1};
              if (word != WORD_INVALID) begin
                speed = word[11:4];
              end
            end else begin
              speed = '0;
            end
          end
          ID_PEDAL: begin
            if (req.byte3 != BYTE_INVALID) begin
              pedal = req.byte3;
            end
          end
          ID_ENGINE: begin
            if (ign) begin
              word = {req.byte6, req.byte5};
              if (word != WORD_INVALID) begin
                rpm = word[15:3];
              end
              word = {req.byte4, req.byte5};
              if (word != WORD_INVALID) begin
                dose_acc = dose_acc + {1'b0, word};
                if (dose_acc >= DOSE_LIMIT) begin
                  flush_dose();
                end
              end
            end else begin
              rpm = '0;
            end
            oil = req.byte3 - OIL_OFFSET;
          end
          ID_DIST_RANGE: begin
            if ({req.byte1[3:0], req.byte2, req.byte3} != DIST_INVALID) begin
              odo = {req.byte1[3:0], req.byte2, req.byte3};
            end
            if ({req.byte4[6:0], req.byte5} != RANGE_INVALID) begin
              range_km = {req.byte4[6:0], req.byte5};
            end
          end
          ID_BRAKE: begin
            if ({req.byte5[3:0], req.byte6} != BRAKE_INVALID) begin
              brake = {req.byte5[3:0], req.byte6};
            end
          end
          ID_ESP: begin
            esp = (req.byte5 != BYTE_INVALID) ? req.byte5[1:0] : 2'd0;
          end
          default: begin
            matched = 1'b0;
          end
        endcase
        if (matched) begin
          stamp = req.now_ms;
        end
      end
      snap.ignition_on   = ign;
      snap.tank_level    = level;
      snap.speed         = speed;
      snap.pedal         = pedal;
      snap.rpm           = rpm;
      snap.oil_degc      = oil;
      snap.distance      = odo;
      snap.range_km      = range_km;
      snap.brake         = brake;
      snap.esp_status    = esp;
      snap.fuel_total_nl = total_nl[47:0];
      snap.timestamp_ms  = stamp;
      expected_snaps.push_back(snap);
    endfunction

    function int field_mismatch(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $error("%s: expected %h, got %h", name, want, seen);
        return 1;
      end
      return 0;
    endfunction

    function void check_snapshot(out_item_t got);
      out_item_t want;
      if (expected_snaps.size() == 0) begin
        $error("snapshot arrived with no request waiting");
        errors++;
        return;
      end
      want = expected_snaps.pop_front();
      errors += field_mismatch("ignition_on", want.ignition_on, got.ignition_on);
      errors += field_mismatch("tank_level", want.tank_level, got.tank_level);
      errors += field_mismatch("speed", want.speed, got.speed);
      errors += field_mismatch("pedal", want.pedal, got.pedal);
      errors += field_mismatch("rpm", want.rpm, got.rpm);
      errors += field_mismatch("oil_degc", want.oil_degc, got.oil_degc);
      errors += field_mismatch("distance", want.distance, got.distance);
      errors += field_mismatch("range_km", want.range_km, got.range_km);
      errors += field_mismatch("brake", want.brake, got.brake);
      errors += field_mismatch("esp_status", want.esp_status, got.esp_status);
      errors += field_mismatch("fuel_total_nl", want.fuel_total_nl, got.fuel_total_nl);
      errors += field_mismatch("timestamp_ms", want.timestamp_ms, got.timestamp_ms);
    endfunction
  endclass

endpackage

[tb/sv/tb_top.sv]
// tb_top: stimulus, handshake driving and result checking for vehicle_can_signal_decoder
// depends on vcsd_pkg, vcsd_tb_pkg and the decoder rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vcsd_pkg::*;
  import vcsd_tb_pkg::*;

  localparam int unsigned RAND_PER_PHASE = 475;
  localparam int unsigned HOLD_CYCLES    = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_ready_i = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  snapshot_tracker sb;

  // idle percentages of the two sides, changed per phase
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 61;
  // set by the stimulus to make the receiver hold off for a long stretch
  bit          hold_req      = 1'b0;

  int unsigned req_count  = 0;
  int unsigned clr_count  = 0;
  int unsigned snap_count = 0;
  int unsigned idle_cycles = 0;

  vehicle_can_signal_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // request building
  // ---------------------------------------------------------------------

  function automatic in_item_t frame_req(logic [28:0] id, logic [63:0] payload,
                                         logic [31:0] now);
    return {KIND_FRAME, id, payload, now};
  endfunction

  // weighted towards ignition and engine frames, which carry the fuel logic
  function automatic logic [28:0] known_id(int unsigned sel);
    case (sel)
      0, 1:    return ID_IGN_FUEL;
      2, 3, 4: return ID_ENGINE;
      5:       return ID_SPEED;
      6:       return ID_PEDAL;
      7:       return ID_DIST_RANGE;
      8:       return ID_BRAKE;
      default: return ID_ESP;
    endcase
  endfunction

  // all-ones bytes show up often so the invalid codes get hit
  function automatic logic [7:0] rand_byte();
    return ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t rand_request();
    logic [28:0] id;
    logic [63:0] payload;
    int unsigned pick;
    payload = '0;
    for (int i = 0; i < 8; i++) begin
      payload = {payload[55:0], rand_byte()};
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      return {KIND_CLEAR, 29'($urandom()), payload, 32'($urandom())};
    end
    if (pick < 8) begin
      // arbitrary identifier, almost always unknown
      id = 29'($urandom());
    end else if (pick < 12) begin
      // near miss: a recognised id with one bit flipped
      id = known_id($urandom_range(0, 9)) ^ (29'd1 << $urandom_range(0, 28));
    end else begin
      id = known_id($urandom_range(0, 9));
    end
    return frame_req(id, payload, 32'($urandom()));
  endfunction

  // ---------------------------------------------------------------------
  // input side driving
  // ---------------------------------------------------------------------

  // random gap first, then offer the request until it is taken; returns at
  // the accepting edge with valid still high so a follow-on request can
  // keep it up without a dip
  task automatic send_request(input in_item_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    sb.note_request(req);
    req_count++;
    if (req.kind == KIND_CLEAR) begin
      clr_count++;
    end
  endtask

  // stop offering and wait until every snapshot has come back
  task automatic drain_snapshots();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (sb.pending() != 0);
  endtask

  // directed requests: extremes, every frame id, invalid codes, ignition
  // off gating, dose threshold and ignition fall flushes, unknown ids, clear
  task automatic run_directed();
    in_item_t plan[$];
    plan.push_back(frame_req(29'h0, 64'h0, 32'h0));
    plan.push_back(frame_req(29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    // speed and engine with ignition still off
    plan.push_back(frame_req(ID_SPEED, 64'h1234_0000_0000_0000, 32'hFFFF_FFFF));
    plan.push_back(frame_req(ID_ENGINE, 64'h0000_0000_1020_3000, 32'($urandom())));
    // ignition on, level invalid then at its top value
    plan.push_back(frame_req(ID_IGN_FUEL, 64'h0000_4000_007F_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_IGN_FUEL, 64'h0000_FF00_00FE_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_SPEED, 64'hFFFF_0000_0000_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_SPEED, 64'hFFF0_0000_0000_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_PEDAL, 64'h0000_00FF_0000_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_PEDAL, 64'h0000_00FE_0000_0000, 32'($urandom())));
    // rpm and dose invalid; dose exactly at the threshold; just under; topped up to it
    plan.push_back(frame_req(ID_ENGINE, 64'h0000_00FF_FFFF_FF00, 32'($urandom())));
    plan.push_back(frame_req(ID_ENGINE, 64'h0000_0028_8009_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_ENGINE, 64'h0000_0000_7FFE_FF00, 32'($urandom())));
    plan.push_back(frame_req(ID_ENGINE, 64'h0000_0000_000B_0000, 32'($urandom())));
    // small dose left in the accumulator, flushed by ignition falling
    plan.push_back(frame_req(ID_ENGINE, 64'h0000_0000_0100_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_IGN_FUEL, 64'h0000_BF00_0000_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_DIST_RANGE, 64'h00FF_FFFF_FFFF_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_DIST_RANGE, 64'h000F_FFFE_7FFE_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_DIST_RANGE, 64'h00F0_0000_8000_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_BRAKE, 64'h0000_0000_000F_FF00, 32'($urandom())));
    plan.push_back(frame_req(ID_BRAKE, 64'h0000_0000_00FF_FE00, 32'($urandom())));
    plan.push_back(frame_req(ID_BRAKE, 64'h0000_0000_00F0_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_ESP, 64'h0000_0000_00FF_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_ESP, 64'h0000_0000_0003_0000, 32'($urandom())));
    plan.push_back(frame_req(ID_ESP, 64'h0000_0000_00FE_0000, 32'($urandom())));
    plan.push_back({KIND_CLEAR, 29'($urandom()), {$urandom(), $urandom()}, 32'($urandom())});
    foreach (plan[i]) begin
      send_request(plan[i]);
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // sender pause until the block has emptied
        if (phase == 1 && n == RAND_PER_PHASE / 2) begin
          drain_snapshots();
        end
        // receiver holds off while requests keep coming back to back
        if (phase == 2 && n == 20) begin
          hold_req = 1'b1;
        end
        send_request(rand_request());
      end
    end

    drain_snapshots();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (%0d fuel clears) and %0d snapshots under three idle mixes,",
             req_count, clr_count, snap_count);
    $display("with one long output hold-off against a full input and one full drain pause");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // output side: ready driving with random stalls and the long hold-off
  // ---------------------------------------------------------------------

  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  // every snapshot taken is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_snapshot(out_data_o);
      snap_count++;
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/core/vcsd_pkg.sv
rtl/core/vcsd_front.sv
rtl/core/vcsd_queue.sv
rtl/core/vcsd_exec.sv
rtl/core/vcsd_fuel.sv
rtl/core/vehicle_can_signal_decoder.sv
tb/sv/vcsd_tb_pkg.sv
tb/sv/tb_top.sv
